/* design/image_header_sniffer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the image header sniffer checks
// Shared property forms, clocked on clk and masked while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef IMAGE_HEADER_SNIFFER_ASSERT_SVH
`define IMAGE_HEADER_SNIFFER_ASSERT_SVH

// Same-cycle implication.
`define IHS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ihs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihs_pkg
// Transaction types, format codes and signature bytes of the header sniffer.
// ----------------------------------------------------------------------------
package ihs_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } ihs_in_t;

    typedef struct packed {
        logic               found;
        logic [2:0]         kind;
        logic signed [31:0] width;
        logic signed [31:0] height;
        logic [15:0]        pixel_depth;
    } ihs_out_t;

    localparam logic [2:0] KIND_UNKNOWN = 3'd0;
    localparam logic [2:0] KIND_PNG     = 3'd1;
    localparam logic [2:0] KIND_JPEG    = 3'd2;
    localparam logic [2:0] KIND_GIF     = 3'd3;
    localparam logic [2:0] KIND_BMP     = 3'd4;

    localparam logic [7:0] BYTE_PNG0 = 8'h89;
    localparam logic [7:0] BYTE_G    = 8'h47;
    localparam logic [7:0] BYTE_I    = 8'h49;
    localparam logic [7:0] BYTE_F    = 8'h46;
    localparam logic [7:0] BYTE_8    = 8'h38;
    localparam logic [7:0] BYTE_7    = 8'h37;
    localparam logic [7:0] BYTE_9    = 8'h39;
    localparam logic [7:0] BYTE_A    = 8'h61;
    localparam logic [7:0] BYTE_B    = 8'h42;
    localparam logic [7:0] BYTE_M    = 8'h4D;
    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] JPG_SOI   = 8'hD8;
    localparam logic [7:0] JPG_EOI   = 8'hD9;
    localparam logic [7:0] JPG_SOS   = 8'hDA;

    // PNG file signature, byte by byte
    function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = 8'h89;
            3'd1:    val = 8'h50;
            3'd2:    val = 8'h4E;
            3'd3:    val = 8'h47;
            3'd4:    val = 8'h0D;
            3'd5:    val = 8'h0A;
            3'd6:    val = 8'h1A;
            default: val = 8'h0A;
        endcase
        return val;
    endfunction

    // SOF0..SOF15 minus DHT, JPG and DAC
    function automatic logic is_frame_marker(input logic [7:0] m);
        return (m[7:4] == 4'hC) && (m != 8'hC4) && (m != 8'hC8) && (m != 8'hCC);
    endfunction

endpackage

/* design/image_header_sniffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_header_sniffer
// Streaming recognizer for PNG, GIF, BMP and JPEG headers.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel:   one file byte per transaction, last_byte marks the final
//                   byte of a file. The next transaction starts a new file.
//   result channel: exactly one transaction per file. On success found=1 with
//                   kind, width, height and pixel_depth. On failure found=0
//                   with zero fields, sent with the last byte of the file.
//   Both channels: transfer when valid is high and stall is low.
// Timing:
//   A byte is registered on accept and decoded in the next cycle; a result
//   then moves into the output register, which drives result_valid.
//   One byte per cycle while no result waits on a stalled output; the
//   per-byte decode is a single pass over the byte register and parser state.
// Stall behavior:
//   A waiting result holds in the output register; bytes that produce no
//   result keep flowing. A byte that would produce a result waits in the
//   input register until the output register frees up.
// Reset:
//   rst_n clears both registers and the parser state; the first byte after
//   reset is byte 0 of a file.
// ----------------------------------------------------------------------------
module image_header_sniffer #(
    parameter int POSITION_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_stall,
    input  ihs_pkg::ihs_in_t byte_data,
    output logic             result_valid,
    input  logic             result_stall,
    output ihs_pkg::ihs_out_t result_data
);

    typedef enum logic [3:0] {
        PH_SEEK,
        PH_MARK,
        PH_LHI,
        PH_LLO,
        PH_SKIP,
        PH_FHI,
        PH_FLO,
        PH_FRAME,
        PH_DEAD
    } phase_t;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // Stage registers
    logic              in_valid_reg, in_valid_next;
    ihs_pkg::ihs_in_t  in_reg, in_next;
    logic              out_valid_reg, out_valid_next;
    ihs_pkg::ihs_out_t out_reg, out_next;

    // Parser state
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [2:0]               guess_reg, guess_next;
    logic                     sig_ok_reg, sig_ok_next;
    logic                     reported_reg, reported_next;
    logic [31:0]              width_reg, width_next;
    logic [31:0]              height_reg, height_next;
    logic [15:0]              depth_reg, depth_next;
    phase_t                   phase_reg, phase_next;
    logic [15:0]              seg_len_reg, seg_len_next;
    logic [15:0]              skip_reg, skip_next;

    // Decode signals
    logic [7:0]  b;
    logic [1:0]  lane_be;
    logic [1:0]  lane_le;
    logic [15:0] skip_inc;
    logic [15:0] seg_new;
    logic [15:0] seg_m2;
    logic        ok_fire;
    logic [2:0]  ok_kind;
    logic        fail_fire;
    logic        emit;
    logic        out_free;
    logic        process;
    logic        accept;

    assign b        = in_reg.data_byte;
    assign lane_be  = 2'd3 - pos_reg[1:0];   // PNG big-endian lanes
    assign lane_le  = pos_reg[1:0] - 2'd2;   // BMP little-endian lanes
    assign skip_inc = (skip_reg == 16'hFFFF) ? skip_reg : skip_reg + 16'd1;
    assign seg_new  = {seg_len_reg[15:8], b};
    assign seg_m2   = seg_len_reg - 16'd2;

    // Per-byte decode
    always_comb
    begin
        guess_next    = guess_reg;
        sig_ok_next   = sig_ok_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        depth_next    = depth_reg;
        phase_next    = phase_reg;
        seg_len_next  = seg_len_reg;
        skip_next     = skip_reg;
        ok_fire       = 1'b0;
        ok_kind       = ihs_pkg::KIND_UNKNOWN;

        if (!reported_reg)
        begin
            if (pos_reg == '0)
            begin
                priority if (b == ihs_pkg::BYTE_PNG0) guess_next = ihs_pkg::KIND_PNG;
                else if (b == ihs_pkg::BYTE_G)        guess_next = ihs_pkg::KIND_GIF;
                else if (b == ihs_pkg::BYTE_B)        guess_next = ihs_pkg::KIND_BMP;
                else if (b == ihs_pkg::BYTE_FF)       guess_next = ihs_pkg::KIND_JPEG;
                else                                  guess_next = ihs_pkg::KIND_UNKNOWN;
                sig_ok_next = (guess_next != ihs_pkg::KIND_UNKNOWN);
            end
            else if (sig_ok_reg)
            begin
                unique case (guess_reg)
                    ihs_pkg::KIND_PNG:
                    begin
                        if (pos_reg < POSITION_BITS'(8))
                        begin
                            if (b != ihs_pkg::png_sig_byte(pos_reg[2:0]))
                                sig_ok_next = 1'b0;
                        end
                        else if (pos_reg >= POSITION_BITS'(16) && pos_reg <= POSITION_BITS'(19))
                            width_next[lane_be*8 +: 8] = b;
                        else if (pos_reg >= POSITION_BITS'(20) && pos_reg <= POSITION_BITS'(23))
                            height_next[lane_be*8 +: 8] = b;
                        else if (pos_reg == POSITION_BITS'(24))
                        begin
                            depth_next = {8'h00, b};
                            ok_fire    = 1'b1;
                            ok_kind    = ihs_pkg::KIND_PNG;
                        end
                    end
                    ihs_pkg::KIND_GIF:
                    begin
                        priority if (pos_reg == POSITION_BITS'(1))
                            sig_ok_next = (b == ihs_pkg::BYTE_I);
                        else if (pos_reg == POSITION_BITS'(2))
                            sig_ok_next = (b == ihs_pkg::BYTE_F);
                        else if (pos_reg == POSITION_BITS'(3))
                            sig_ok_next = (b == ihs_pkg::BYTE_8);
                        else if (pos_reg == POSITION_BITS'(4))
                            sig_ok_next = (b == ihs_pkg::BYTE_7) || (b == ihs_pkg::BYTE_9);
                        else if (pos_reg == POSITION_BITS'(5))
                            sig_ok_next = (b == ihs_pkg::BYTE_A);
                        else if (pos_reg == POSITION_BITS'(6))
                            width_next = {24'h0, b};
                        else if (pos_reg == POSITION_BITS'(7))
                            width_next[15:8] = b;
                        else if (pos_reg == POSITION_BITS'(8))
                            height_next = {24'h0, b};
                        else if (pos_reg == POSITION_BITS'(9))
                        begin
                            height_next[15:8] = b;
                            ok_fire = 1'b1;
                            ok_kind = ihs_pkg::KIND_GIF;
                        end
                    end
                    ihs_pkg::KIND_BMP:
                    begin
                        if (pos_reg == POSITION_BITS'(1))
                            sig_ok_next = (b == ihs_pkg::BYTE_M);
                        else if (pos_reg >= POSITION_BITS'(18) && pos_reg <= POSITION_BITS'(21))
                            width_next[lane_le*8 +: 8] = b;
                        else if (pos_reg >= POSITION_BITS'(22) && pos_reg <= POSITION_BITS'(25))
                            height_next[lane_le*8 +: 8] = b;
                        else if (pos_reg == POSITION_BITS'(28))
                            depth_next[7:0] = b;
                        else if (pos_reg == POSITION_BITS'(29))
                        begin
                            depth_next[15:8] = b;
                            ok_fire = 1'b1;
                            ok_kind = ihs_pkg::KIND_BMP;
                        end
                    end
                    ihs_pkg::KIND_JPEG:
                    begin
                        if (pos_reg == POSITION_BITS'(1))
                            sig_ok_next = (b == ihs_pkg::JPG_SOI);
                        else
                        begin
                            unique case (phase_reg)
                                PH_SEEK:
                                    if (b == ihs_pkg::BYTE_FF)
                                        phase_next = PH_MARK;
                                PH_MARK:
                                    if (b == ihs_pkg::JPG_EOI || b == ihs_pkg::JPG_SOS)
                                        phase_next = PH_DEAD;
                                    else if (ihs_pkg::is_frame_marker(b))
                                        phase_next = PH_FHI;
                                    else
                                        phase_next = PH_LHI;
                                PH_LHI:
                                begin
                                    seg_len_next = {b, 8'h00};
                                    phase_next   = PH_LLO;
                                end
                                PH_FHI:
                                begin
                                    seg_len_next = {b, 8'h00};
                                    phase_next   = PH_FLO;
                                end
                                PH_LLO:
                                begin
                                    seg_len_next = seg_new;
                                    priority if (seg_new < 16'd2)
                                        phase_next = PH_DEAD;
                                    else if (seg_new == 16'd2)
                                        phase_next = PH_SEEK;
                                    else
                                    begin
                                        skip_next  = seg_new - 16'd2;
                                        phase_next = PH_SKIP;
                                    end
                                end
                                PH_SKIP:
                                begin
                                    if (skip_reg != 16'd0)
                                        skip_next = skip_reg - 16'd1;
                                    if (skip_next == 16'd0)
                                        phase_next = PH_SEEK;
                                end
                                PH_FLO:
                                begin
                                    seg_len_next = seg_new;
                                    if (seg_new < 16'd2)
                                        phase_next = PH_DEAD;
                                    else
                                    begin
                                        skip_next  = 16'd0;
                                        phase_next = PH_FRAME;
                                    end
                                end
                                PH_FRAME:
                                begin
                                    // skip counts bytes after the length field
                                    skip_next = skip_inc;
                                    unique case (skip_inc)
                                        16'd1:   depth_next  = {8'h00, b};
                                        16'd2:   height_next = {16'h0, b, 8'h00};
                                        16'd3:   height_next[7:0] = b;
                                        16'd4:   width_next  = {16'h0, b, 8'h00};
                                        16'd5:   width_next[7:0] = b;
                                        default: ;
                                    endcase
                                    if (skip_inc >= 16'd6 && skip_inc >= seg_m2)
                                    begin
                                        ok_fire = 1'b1;
                                        ok_kind = ihs_pkg::KIND_JPEG;
                                    end
                                end
                                default: ;  // dead: scan stopped
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign fail_fire = !reported_reg && !ok_fire && in_reg.last_byte;
    assign emit      = ok_fire || fail_fire;
    assign out_free  = !out_valid_reg || !result_stall;
    assign process   = in_valid_reg && (!emit || out_free);
    assign byte_stall = in_valid_reg && !process;
    assign accept    = byte_valid && !byte_stall;

    // Handshake and end-of-file handling
    always_comb
    begin
        reported_next = reported_reg || ok_fire;
        pos_next      = (pos_reg != POS_MAX) ? pos_reg + POSITION_BITS'(1) : pos_reg;

        in_next       = accept ? byte_data : in_reg;
        in_valid_next = accept ? 1'b1 : (process ? 1'b0 : in_valid_reg);

        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (process && emit)
        begin
            out_valid_next = 1'b1;
            if (ok_fire)
            begin
                out_next.found       = 1'b1;
                out_next.kind        = ok_kind;
                out_next.width       = width_next;
                out_next.height      = height_next;
                out_next.pixel_depth = (ok_kind == ihs_pkg::KIND_GIF) ? 16'h0 : depth_next;
            end
            else
            begin
                out_next.found = 1'b0;
                // a failed JPEG still names its format once 8 bytes are in
                out_next.kind  = (guess_next == ihs_pkg::KIND_JPEG && sig_ok_next &&
                                  pos_reg >= POSITION_BITS'(7)) ?
                                 ihs_pkg::KIND_JPEG : ihs_pkg::KIND_UNKNOWN;
                out_next.width       = '0;
                out_next.height      = '0;
                out_next.pixel_depth = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            pos_reg       <= '0;
            guess_reg     <= ihs_pkg::KIND_UNKNOWN;
            sig_ok_reg    <= 1'b1;
            reported_reg  <= 1'b0;
            width_reg     <= '0;
            height_reg    <= '0;
            depth_reg     <= '0;
            phase_reg     <= PH_SEEK;
            seg_len_reg   <= '0;
            skip_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            in_reg        <= in_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            if (process)
            begin
                if (in_reg.last_byte)
                begin
                    // file done: back to the start-of-file state
                    pos_reg      <= '0;
                    guess_reg    <= ihs_pkg::KIND_UNKNOWN;
                    sig_ok_reg   <= 1'b1;
                    reported_reg <= 1'b0;
                    width_reg    <= '0;
                    height_reg   <= '0;
                    depth_reg    <= '0;
                    phase_reg    <= PH_SEEK;
                    seg_len_reg  <= '0;
                    skip_reg     <= '0;
                end
                else
                begin
                    pos_reg      <= pos_next;
                    guess_reg    <= guess_next;
                    sig_ok_reg   <= sig_ok_next;
                    reported_reg <= reported_next;
                    width_reg    <= width_next;
                    height_reg   <= height_next;
                    depth_reg    <= depth_next;
                    phase_reg    <= phase_next;
                    seg_len_reg  <= seg_len_next;
                    skip_reg     <= skip_next;
                end
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

/* design/ihs_port_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihs_port_checker
// Port-level checks of the header sniffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "image_header_sniffer_assert.svh"

module ihs_port_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              byte_valid,
    input logic              byte_stall,
    input ihs_pkg::ihs_in_t  byte_data,
    input logic              result_valid,
    input logic              result_stall,
    input ihs_pkg::ihs_out_t result_data
);

    `IHS_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(result_data), "stalled result transaction changed")

    `IHS_ASSERT_NEXT(a_byte_hold, byte_valid && byte_stall,
        byte_valid && $stable(byte_data), "stalled byte transaction changed")

    `IHS_ASSERT_NOW(a_fail_fields_zero, result_valid && !result_data.found,
        result_data.width == 0 && result_data.height == 0 && result_data.pixel_depth == 0,
        "failure carries nonzero fields")

    `IHS_ASSERT_NOW(a_fail_kind, result_valid && !result_data.found,
        result_data.kind == ihs_pkg::KIND_UNKNOWN || result_data.kind == ihs_pkg::KIND_JPEG,
        "failure with bad kind")

    `IHS_ASSERT_NOW(a_gif_depth,
        result_valid && result_data.found && result_data.kind == ihs_pkg::KIND_GIF,
        result_data.pixel_depth == 0, "GIF result with depth")

endmodule

bind image_header_sniffer ihs_port_checker u_ihs_port_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);

/* tb/image_header_sniffer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_header_sniffer_tb
// Self-checking bench for the image header sniffer. Whole files are streamed
// one byte per transaction. First come hand-built PNG, GIF, BMP and JPEG
// files that hit the corner cases, then at least 460 bytes of random
// files: mostly well-formed headers with random content, some corrupted,
// truncated or pure noise. A byte-level parser model predicts the result of
// each file, and every result transaction is checked against it in order.
// Both channels idle at random, and the result side holds off once for a
// long stretch so that the block backs up into its byte channel.
// ----------------------------------------------------------------------------
module image_header_sniffer_tb;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_BYTES   = 460;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    // margin after the last result has passed the input and output registers
    localparam int DRAIN_CYCLES   = 10;

    localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;

    // JPEG marker codes used by the stimulus and the frame-marker test
    localparam logic [7:0] MARK_SOF0  = 8'hC0;
    localparam logic [7:0] MARK_SOF2  = 8'hC2;
    localparam logic [7:0] MARK_DHT   = 8'hC4;
    localparam logic [7:0] MARK_JPG   = 8'hC8;
    localparam logic [7:0] MARK_DAC   = 8'hCC;
    localparam logic [7:0] MARK_SOF15 = 8'hCF;
    localparam logic [7:0] MARK_APP0  = 8'hE0;
    localparam logic [7:0] MARK_COM   = 8'hFE;

    // JPEG marker scanner phases
    typedef enum logic [3:0] {
        SCAN_SEEK,
        SCAN_MARK,
        SCAN_LEN_HI,
        SCAN_LEN_LO,
        SCAN_SKIP,
        SCAN_SOF_HI,
        SCAN_SOF_LO,
        SCAN_SOF,
        SCAN_DEAD
    } scan_phase_t;

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               byte_valid   = 1'b0;
    logic               byte_stall;
    ihs_pkg::ihs_in_t   byte_data    = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    ihs_pkg::ihs_out_t  result_data;

    image_header_sniffer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // ------------------------------------------------------------------------
    // Stimulus and scoreboard storage
    // ------------------------------------------------------------------------
    ihs_pkg::ihs_in_t   pending_bytes[$];     // bytes still to be sent
    ihs_pkg::ihs_out_t  expected_headers[$];  // predicted results, oldest first
    logic [7:0]         file_buf[$];          // file under construction

    int mismatch_count = 0;
    int headers_seen   = 0;
    int idle_cycles    = 0;

    // ------------------------------------------------------------------------
    // Parser model state; cleared at start and after each last byte
    // ------------------------------------------------------------------------
    logic [31:0] pos;
    logic [2:0]  guess;
    bit          sig_ok;
    bit          header_sent;
    logic [31:0] w_acc;
    logic [31:0] h_acc;
    logic [15:0] d_acc;
    scan_phase_t phase;
    logic [15:0] seg_len;
    logic [15:0] skip_cnt;

    function automatic void clear_parser();
        pos         = '0;
        guess       = ihs_pkg::KIND_UNKNOWN;
        sig_ok      = 1'b1;
        header_sent = 1'b0;
        w_acc       = '0;
        h_acc       = '0;
        d_acc       = '0;
        phase       = SCAN_SEEK;
        seg_len     = '0;
        skip_cnt    = '0;
    endfunction

    // SOF0..SOF15 except DHT, JPG and DAC, which share the 0xCx range
    function automatic bit is_sof_code(input logic [7:0] m);
        return (m >= MARK_SOF0) && (m <= MARK_SOF15) &&
               (m != MARK_DHT) && (m != MARK_JPG) && (m != MARK_DAC);
    endfunction

    function automatic ihs_pkg::ihs_out_t header_result(input logic f, input logic [2:0] k,
                                                        input logic [31:0] w,
                                                        input logic [31:0] h,
                                                        input logic [15:0] d);
        ihs_pkg::ihs_out_t r;
        r.found       = f;
        r.kind        = k;
        r.width       = w;
        r.height      = h;
        r.pixel_depth = d;
        return r;
    endfunction

    // JPEG segment walker, called for each byte from index 2 on while the signature holds and no result is out
    function automatic bit scan_jpeg(input logic [7:0] b, output ihs_pkg::ihs_out_t res);
        res = '0;
        case (phase)
            SCAN_SEEK:
                if (b == ihs_pkg::BYTE_FF) phase = SCAN_MARK;
            SCAN_MARK:
                if (b == ihs_pkg::JPG_EOI || b == ihs_pkg::JPG_SOS) phase = SCAN_DEAD;
                else phase = is_sof_code(b) ? SCAN_SOF_HI : SCAN_LEN_HI;
            SCAN_LEN_HI:
            begin
                seg_len = {b, 8'h00};
                phase   = SCAN_LEN_LO;
            end
            SCAN_SOF_HI:
            begin
                seg_len = {b, 8'h00};
                phase   = SCAN_SOF_LO;
            end
            SCAN_LEN_LO:
            begin
                seg_len = seg_len | {8'h00, b};
                if (seg_len < 16'd2) phase = SCAN_DEAD;
                else if (seg_len == 16'd2) phase = SCAN_SEEK;
                else
                begin
                    skip_cnt = seg_len - 16'd2;
                    phase    = SCAN_SKIP;
                end
            end
            SCAN_SKIP:
            begin
                if (skip_cnt != 16'd0) skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 16'd0) phase = SCAN_SEEK;
            end
            SCAN_SOF_LO:
            begin
                seg_len = seg_len | {8'h00, b};
                if (seg_len < 16'd2) phase = SCAN_DEAD;
                else
                begin
                    skip_cnt = '0;
                    phase    = SCAN_SOF;
                end
            end
            SCAN_SOF:
            begin
                if (skip_cnt != 16'hFFFF) skip_cnt = skip_cnt + 16'd1;
                case (skip_cnt)
                    16'd1: d_acc = {8'h00, b};
                    16'd2: h_acc = {16'h0000, b, 8'h00};
                    16'd3: h_acc = h_acc | {24'h0, b};
                    16'd4: w_acc = {16'h0000, b, 8'h00};
                    16'd5: w_acc = w_acc | {24'h0, b};
                    default: ;
                endcase
                // done at the tenth byte from FF and once the segment is in
                if (skip_cnt >= 16'd6 && {16'h0, skip_cnt} >= {16'h0, seg_len} - 32'd2)
                begin
                    res = header_result(1'b1, ihs_pkg::KIND_JPEG, w_acc, h_acc, d_acc);
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // One accepted byte in, at most one predicted result out
    function automatic bit step_header(input ihs_pkg::ihs_in_t item,
                                       output ihs_pkg::ihs_out_t res);
        logic [7:0]  b;
        logic [31:0] i;
        bit          hit;
        logic [2:0]  fail_kind;
        b   = item.data_byte;
        i   = pos;
        hit = 1'b0;
        res = '0;
        if (!header_sent)
        begin
            if (i == 0)
            begin
                case (b)
                    ihs_pkg::BYTE_PNG0: guess = ihs_pkg::KIND_PNG;
                    ihs_pkg::BYTE_G:    guess = ihs_pkg::KIND_GIF;
                    ihs_pkg::BYTE_B:    guess = ihs_pkg::KIND_BMP;
                    ihs_pkg::BYTE_FF:   guess = ihs_pkg::KIND_JPEG;
                    default:            guess = ihs_pkg::KIND_UNKNOWN;
                endcase
                sig_ok = (guess != ihs_pkg::KIND_UNKNOWN);
            end
            else if (sig_ok)
            begin
                case (guess)
                    ihs_pkg::KIND_PNG:
                        if (i < 8)
                        begin
                            if (b != PNG_MAGIC[8 * (7 - i[2:0]) +: 8]) sig_ok = 1'b0;
                        end
                        else if (i >= 16 && i <= 19) w_acc = {w_acc[23:0], b};
                        else if (i >= 20 && i <= 23) h_acc = {h_acc[23:0], b};
                        else if (i == 24)
                        begin
                            d_acc = {8'h00, b};
                            res   = header_result(1'b1, ihs_pkg::KIND_PNG, w_acc, h_acc,
                                                  d_acc);
                            hit   = 1'b1;
                        end
                    ihs_pkg::KIND_GIF:
                        if (i == 1) sig_ok = (b == ihs_pkg::BYTE_I);
                        else if (i == 2) sig_ok = (b == ihs_pkg::BYTE_F);
                        else if (i == 3) sig_ok = (b == ihs_pkg::BYTE_8);
                        else if (i == 4) sig_ok = (b == ihs_pkg::BYTE_7 || b == ihs_pkg::BYTE_9);
                        else if (i == 5) sig_ok = (b == ihs_pkg::BYTE_A);
                        else if (i == 6) w_acc = {24'h0, b};
                        else if (i == 7) w_acc = w_acc | {16'h0, b, 8'h00};
                        else if (i == 8) h_acc = {24'h0, b};
                        else if (i == 9)
                        begin
                            h_acc = h_acc | {16'h0, b, 8'h00};
                            res   = header_result(1'b1, ihs_pkg::KIND_GIF, w_acc, h_acc,
                                                  16'h0);
                            hit   = 1'b1;
                        end
                    ihs_pkg::KIND_BMP:
                        if (i == 1) sig_ok = (b == ihs_pkg::BYTE_M);
                        else if (i >= 18 && i <= 21)
                            w_acc = w_acc | ({24'h0, b} << (8 * (i - 18)));
                        else if (i >= 22 && i <= 25)
                            h_acc = h_acc | ({24'h0, b} << (8 * (i - 22)));
                        else if (i == 28) d_acc = {8'h00, b};
                        else if (i == 29)
                        begin
                            d_acc = d_acc | {b, 8'h00};
                            res   = header_result(1'b1, ihs_pkg::KIND_BMP, w_acc, h_acc,
                                                  d_acc);
                            hit   = 1'b1;
                        end
                    ihs_pkg::KIND_JPEG:
                        if (i == 1) sig_ok = (b == ihs_pkg::JPG_SOI);
                        else hit = scan_jpeg(b, res);
                    default: ;
                endcase
            end
            if (hit) header_sent = 1'b1;
            else if (item.last_byte)
            begin
                // a failed JPEG keeps its kind only past the short-file limit
                fail_kind = (guess == ihs_pkg::KIND_JPEG && sig_ok && i >= 7) ?
                            ihs_pkg::KIND_JPEG : ihs_pkg::KIND_UNKNOWN;
                res = header_result(1'b0, fail_kind, '0, '0, '0);
                hit = 1'b1;
            end
        end
        if (pos != 32'hFFFF_FFFF) pos = pos + 32'd1;
        if (item.last_byte) clear_parser();
        return hit;
    endfunction

    // ------------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------------
    task automatic add(input logic [7:0] b);
        file_buf.push_back(b);
    endtask

    task automatic add_rand(input int n);
        repeat (n) add(8'($urandom));
    endtask

    task automatic add_be(input logic [31:0] v, input int n);
        for (int k = n - 1; k >= 0; k--) add(v[8 * k +: 8]);
    endtask

    task automatic add_le(input logic [31:0] v, input int n);
        for (int k = 0; k < n; k++) add(v[8 * k +: 8]);
    endtask

    task automatic png_file(input logic [31:0] w, input logic [31:0] h,
                            input logic [7:0] d, input int tail);
        for (int k = 7; k >= 0; k--) add(PNG_MAGIC[8 * k +: 8]);
        add_rand(8);                // IHDR length and chunk type
        add_be(w, 4);
        add_be(h, 4);
        add(d);
        add_rand(tail);
    endtask

    task automatic gif_file(input logic [7:0] ver, input logic [15:0] w,
                            input logic [15:0] h, input int tail);
        add(ihs_pkg::BYTE_G);
        add(ihs_pkg::BYTE_I);
        add(ihs_pkg::BYTE_F);
        add(ihs_pkg::BYTE_8);
        add(ver);
        add(ihs_pkg::BYTE_A);
        add_le(w, 2);
        add_le(h, 2);
        add_rand(tail);
    endtask

    task automatic bmp_file(input logic [31:0] w, input logic [31:0] h,
                            input logic [15:0] d, input int tail);
        add(ihs_pkg::BYTE_B);
        add(ihs_pkg::BYTE_M);
        add_rand(16);
        add_le(w, 4);
        add_le(h, 4);
        add_rand(2);
        add_le(d, 2);
        add_rand(tail);
    endtask

    task automatic jpeg_segment(input logic [7:0] marker, input logic [15:0] len);
        add(ihs_pkg::BYTE_FF);
        add(marker);
        add_be(len, 2);
        if (len > 16'd2) add_rand(int'(len) - 2);
    endtask

    // frame header plus enough payload to finish both the ten bytes and the segment
    task automatic jpeg_frame(input logic [7:0] marker, input logic [15:0] len,
                              input logic [7:0] prec, input logic [15:0] h,
                              input logic [15:0] w);
        add(ihs_pkg::BYTE_FF);
        add(marker);
        add_be(len, 2);
        add(prec);
        add_be(h, 2);
        add_be(w, 2);
        add_rand((len > 16'd8) ? int'(len) - 7 : 1);
    endtask

    // queue the file; keep > 0 truncates it, flip_at >= 0 corrupts one byte
    task automatic end_file(input int keep, input int flip_at);
        ihs_pkg::ihs_in_t item;
        int               n;
        if (flip_at >= 0 && flip_at < file_buf.size())
            file_buf[flip_at] = file_buf[flip_at] ^ 8'($urandom_range(1, 255));
        n = (keep > 0 && keep < file_buf.size()) ? keep : file_buf.size();
        for (int k = 0; k < n; k++)
        begin
            item.data_byte = file_buf[k];
            item.last_byte = (k == n - 1);
            pending_bytes.push_back(item);
        end
        file_buf.delete();
    endtask

    // mostly zero, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Byte driver: offers queued bytes with random gaps and predicts each
    // transaction as it is accepted. A stalled byte is held unchanged.
    // ------------------------------------------------------------------------
    int                send_gap  = 0;
    int                send_calm = 0;
    ihs_pkg::ihs_out_t predicted;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_data  <= '0;
            send_gap   <= 0;
            send_calm  <= 0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                if (step_header(byte_data, predicted)) expected_headers.push_back(predicted);
            end
            if (!byte_valid || !byte_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap   <= send_gap - 1;
                    byte_valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    byte_data  <= pending_bytes.pop_front();
                    byte_valid <= 1'b1;
                    // calm stretches send back to back
                    if (send_calm > 0)
                    begin
                        send_calm <= send_calm - 1;
                        send_gap  <= 0;
                    end
                    else
                    begin
                        send_gap <= pick_gap();
                        if ($urandom_range(0, 49) == 0) send_calm <= $urandom_range(30, 120);
                    end
                end
                else byte_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver stall. Random stalls, calm stretches, and one long
    // hold-off after a few results so the block backs up into the byte side.
    // ------------------------------------------------------------------------
    int stall_left   = 0;
    int recv_calm    = 0;
    int stall_pick   = 0;
    bit holdoff_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
            recv_calm    <= 0;
            holdoff_done <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else if (!holdoff_done && headers_seen >= 4)
        begin
            holdoff_done <= 1'b1;
            result_stall <= 1'b1;
            stall_left   <= HOLDOFF_CYCLES;
        end
        else if (recv_calm > 0)
        begin
            result_stall <= 1'b0;
            recv_calm    <= recv_calm - 1;
        end
        else
        begin
            stall_pick = pick_gap();
            if (stall_pick > 0)
            begin
                result_stall <= 1'b1;
                stall_left   <= stall_pick - 1;
            end
            else
            begin
                result_stall <= 1'b0;
                if ($urandom_range(0, 49) == 0) recv_calm <= $urandom_range(30, 120);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: each accepted result transaction against the oldest prediction
    // ------------------------------------------------------------------------
    ihs_pkg::ihs_out_t wanted;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            headers_seen <= headers_seen + 1;
            if (expected_headers.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result found=%0d kind=%0d w=%0d h=%0d bpp=%0d",
                             $realtime, result_data.found, result_data.kind,
                             result_data.width, result_data.height,
                             result_data.pixel_depth);
            end
            else
            begin
                wanted = expected_headers.pop_front();
                if (result_data.found !== wanted.found || result_data.kind !== wanted.kind ||
                    result_data.width !== wanted.width || result_data.height !== wanted.height ||
                    result_data.pixel_depth !== wanted.pixel_depth)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch exp found=%0d kind=%0d w=%0d h=%0d bpp=%0d %s",
                                 $realtime, wanted.found, wanted.kind, wanted.width,
                                 wanted.height, wanted.pixel_depth,
                                 $sformatf("got found=%0d kind=%0d w=%0d h=%0d bpp=%0d",
                                           result_data.found, result_data.kind,
                                           result_data.width, result_data.height,
                                           result_data.pixel_depth));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles with work outstanding but no transaction on either side
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (result_valid && !result_stall) ||
            (pending_bytes.size() == 0 && !byte_valid && expected_headers.size() == 0))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int         stim_start;
        int         pick;
        int         keep;
        int         flip_at;
        logic [7:0] m;

        clear_parser();

        // --- directed files ---
        // PNG at full-scale sizes; bytes after the header are ignored
        png_file(32'hFFFF_FFFF, 32'h8000_0000, 8'hFF, 3);
        end_file(0, -1);
        // PNG with a broken signature
        png_file(32'd1, 32'd1, 8'd8, 0);
        end_file(0, 3);
        // GIF87a and GIF89a, the latter ending right at the header
        gif_file(ihs_pkg::BYTE_7, 16'hFFFF, 16'h0000, 2);
        end_file(0, -1);
        gif_file(ihs_pkg::BYTE_9, 16'h0000, 16'hFFFF, 0);
        end_file(0, -1);
        // GIF with a bad version byte
        gif_file(ihs_pkg::BYTE_8, 16'd5, 16'd5, 0);
        end_file(0, -1);
        // BMP with a negative height; BMP with a bad second byte
        bmp_file(32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0);
        end_file(0, -1);
        bmp_file(32'h8000_0000, 32'h0, 16'h0, 1);
        end_file(0, 1);
        // JPEG: APP0, then a frame whose segment outlasts the ten bytes
        add(ihs_pkg::BYTE_FF);
        add(ihs_pkg::JPG_SOI);
        jpeg_segment(MARK_APP0, 16'd4);
        jpeg_frame(MARK_SOF0, 16'd17, 8'h08, 16'hFFFF, 16'h0001);
        end_file(0, -1);
        // fill-byte marker with a bare length, then the shortest frame length
        add(ihs_pkg::BYTE_FF);
        add(ihs_pkg::JPG_SOI);
        jpeg_segment(ihs_pkg::BYTE_FF, 16'd2);
        jpeg_frame(MARK_SOF2, 16'd2, 8'hFF, 16'h0000, 16'hFFFF);
        end_file(0, -1);
        // segment with a nonzero high length byte
        add(ihs_pkg::BYTE_FF);
        add(ihs_pkg::JPG_SOI);
        jpeg_segment(MARK_COM, 16'h0104);
        jpeg_frame(MARK_SOF15, 16'd8, 8'h0C, 16'h1234, 16'h8000);
        end_file(0, -1);
        // end-of-image and start-of-scan stop the scan
        add(ihs_pkg::BYTE_FF);
        add(ihs_pkg::JPG_SOI);
        add(ihs_pkg::BYTE_FF);
        add(ihs_pkg::JPG_EOI);
        add_rand(8);
        end_file(0, -1);
        add(ihs_pkg::BYTE_FF);
        add(ihs_pkg::JPG_SOI);
        add(ihs_pkg::BYTE_FF);
        add(ihs_pkg::JPG_SOS);
        add_rand(4);
        end_file(0, -1);
        // segment length below two
        add(ihs_pkg::BYTE_FF);
        add(ihs_pkg::JPG_SOI);
        jpeg_segment(MARK_APP0, 16'd1);
        add_rand(4);
        end_file(0, -1);
        // file ends inside a frame segment
        add(ihs_pkg::BYTE_FF);
        add(ihs_pkg::JPG_SOI);
        jpeg_frame(MARK_SOF0, 16'd16, 8'h08, 16'd64, 16'd64);
        end_file(12, -1);
        // seven bytes report unknown, eight report JPEG
        add(ihs_pkg::BYTE_FF);
        add(ihs_pkg::JPG_SOI);
        add_rand(5);
        end_file(0, -1);
        add(ihs_pkg::BYTE_FF);
        add(ihs_pkg::JPG_SOI);
        add_rand(6);
        end_file(0, -1);
        // bad start-of-image, one-byte file, unknown first byte
        add(ihs_pkg::BYTE_FF);
        add(8'h00);
        add_rand(8);
        end_file(0, -1);
        add(ihs_pkg::BYTE_FF);
        end_file(0, -1);
        add(8'h00);
        add_rand(5);
        end_file(0, -1);

        // --- random files ---
        stim_start = pending_bytes.size();
        while (pending_bytes.size() < stim_start + RANDOM_BYTES)
        begin
            pick    = $urandom_range(0, 99);
            flip_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 40) : -1;
            keep    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) : 0;
            if (pick < 15)
                png_file($urandom, $urandom, 8'($urandom), $urandom_range(0, 3));
            else if (pick < 30)
                gif_file($urandom_range(0, 1) ? ihs_pkg::BYTE_7 : ihs_pkg::BYTE_9,
                         16'($urandom), 16'($urandom), $urandom_range(0, 3));
            else if (pick < 45)
                bmp_file($urandom, $urandom, 16'($urandom), $urandom_range(0, 3));
            else if (pick < 88)
            begin
                add(ihs_pkg::BYTE_FF);
                add(ihs_pkg::JPG_SOI);
                repeat ($urandom_range(0, 3))
                begin
                    // junk between segments is skipped while seeking a marker
                    if ($urandom_range(0, 3) == 0) add(8'($urandom_range(0, 254)));
                    m = 8'($urandom);
                    if ((is_sof_code(m) || m == ihs_pkg::JPG_EOI || m == ihs_pkg::JPG_SOS) &&
                        $urandom_range(0, 7) != 0)
                        m = MARK_APP0 | 8'($urandom_range(0, 15));
                    jpeg_segment(m, ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 1))
                                                                 : 16'($urandom_range(2, 10)));
                end
                jpeg_frame({4'hC, 4'($urandom)}, 16'($urandom_range(0, 20)), 8'($urandom),
                           16'($urandom), 16'($urandom));
                add_rand($urandom_range(0, 3));
            end
            else add_rand($urandom_range(1, 12));
            end_file(keep, flip_at);
        end

        // --- reset, then let the driver run ---
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_bytes.size() != 0 || byte_valid || expected_headers.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/ihs_pkg.sv
design/image_header_sniffer.sv
design/ihs_port_checker.sv
tb/image_header_sniffer_tb.sv
